/* rtl/ps2_mouse_packet_tracker_defines.svh */
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// same-cycle implication
`define PS2MT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PS2MT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ps2mt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Types and constants shared by the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

  localparam int DIM_W          = 13;
  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_IDX_W      = 1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd768;

  // status byte bit positions
  localparam int ST_LEFT   = 0;
  localparam int ST_RIGHT  = 1;
  localparam int ST_MIDDLE = 2;
  localparam int ST_SYNC   = 3;
  localparam int ST_XSIGN  = 4;
  localparam int ST_YSIGN  = 5;
  localparam int ST_XOVF   = 6;
  localparam int ST_YOVF   = 7;

  localparam logic signed [9:0] OVF_MAG = 10'sd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_t;

  // framer -> cursor unit
  typedef struct packed {
    logic       expect_last;  // next accepted word completes a packet
    logic       fire;         // packet completes on this accept
    logic [7:0] status;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

endpackage

`default_nettype wire

/* rtl/ps2mt_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mt interfaces
// Valid/ready channels for received mouse words and cursor results.
// ----------------------------------------------------------------------------
interface ps2mt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2mt_cursor_if import ps2mt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  left_pressed;
  logic                  right_pressed;
  logic                  middle_pressed;

  modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                  output right_pressed, output middle_pressed, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input left_pressed,
                input right_pressed, input middle_pressed, output ready);
endinterface

`default_nettype wire

/* rtl/ps2mt_framer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mt_framer
// Drops the first word after reset and frames status / X / Y packets.
// ----------------------------------------------------------------------------
module ps2mt_framer import ps2mt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output pkt_t            pkt
);

  phase_t     phase, phase_next;
  logic       drop_first, drop_first_next;
  logic       load_status, load_dx;
  logic       fire;
  logic [7:0] status_hold;
  logic [7:0] dx_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_STATUS;
      drop_first <= 1'b1;
    end else begin
      phase      <= phase_next;
      drop_first <= drop_first_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      status_hold <= rx_byte;
    end
    if (load_dx) begin
      dx_hold <= rx_byte;
    end
  end

  always_comb begin
    phase_next      = phase;
    drop_first_next = drop_first;
    load_status     = 1'b0;
    load_dx         = 1'b0;
    fire            = 1'b0;
    if (accept) begin
      if (drop_first) begin
        drop_first_next = 1'b0;
      end else begin
        case (phase)
          PH_DX: begin
            load_dx    = 1'b1;
            phase_next = PH_DY;
          end
          PH_DY: begin
            fire       = 1'b1;
            phase_next = PH_STATUS;
          end
          default: begin
            // only a word with the sync bit set starts a packet
            if (rx_byte[ST_SYNC]) begin
              load_status = 1'b1;
              phase_next  = PH_DX;
            end else begin
              phase_next = PH_STATUS;
            end
          end
        endcase
      end
    end
  end

  assign pkt = '{
    expect_last: !drop_first && (phase == PH_DY),
    fire:        fire,
    status:      status_hold,
    dx:          dx_hold,
    dy:          rx_byte
  };

endmodule

`default_nettype wire

/* rtl/ps2mt_cursor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mt_cursor
// Screen limits, delta decode, position update with clamp, result register.
// ----------------------------------------------------------------------------
module ps2mt_cursor import ps2mt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire pkt_t                 pkt,
  ps2mt_cursor_if.source            res
);

  localparam int CMP_W = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
  localparam int SUM_W = ((COORD_BITS > 10) ? COORD_BITS : 10) + 2;
  localparam logic [COORD_BITS-1:0] COORD_MASK = '1;

  // largest coordinate for a screen dimension; zero acts like one
  function automatic logic [COORD_BITS-1:0] dim_limit(input logic [DIM_W-1:0] dim);
    logic [CMP_W-1:0] top;
    top = (dim == '0) ? '0 : (CMP_W'(dim) - CMP_W'(1));
    if (top > CMP_W'(COORD_MASK)) begin
      top = CMP_W'(COORD_MASK);
    end
    return top[COORD_BITS-1:0];
  endfunction

  // 9-bit two's complement delta, widened by 255 on overflow
  function automatic logic signed [9:0] movement(input logic [7:0] raw, input logic neg,
                                                 input logic ovf);
    logic signed [9:0] d;
    d = $signed({neg, neg, raw});
    if (ovf) begin
      d = neg ? (d - OVF_MAG) : (d + OVF_MAG);
    end
    return d;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                  input logic [COORD_BITS-1:0] lim);
    logic signed [SUM_W-1:0] lim_ext;
    lim_ext = $signed({{(SUM_W-COORD_BITS){1'b0}}, lim});
    if (v < 0) begin
      return '0;
    end
    if (v > lim_ext) begin
      return lim;
    end
    return v[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0]   lim_x, lim_y;
  logic [COORD_BITS-1:0]   pos_x, pos_y;
  logic [COORD_BITS-1:0]   pos_x_next, pos_y_next;
  logic [2:0]              buttons;
  logic                    valid;
  logic signed [9:0]       dx, dy;
  logic signed [SUM_W-1:0] nx, ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_x <= dim_limit(RESET_WIDTH);
      lim_y <= dim_limit(RESET_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  lim_x <= dim_limit(cfg_data);
        CFG_HEIGHT: lim_y <= dim_limit(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    dx = movement(pkt.dx, pkt.status[ST_XSIGN], pkt.status[ST_XOVF]);
    dy = movement(pkt.dy, pkt.status[ST_YSIGN], pkt.status[ST_YOVF]);
    nx = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_x}) + SUM_W'(dx);
    // screen rows grow downward
    ny = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_y}) - SUM_W'(dy);
    pos_x_next = clamp(nx, lim_x);
    pos_y_next = clamp(ny, lim_y);
  end

  // position registers double as the result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      valid <= 1'b0;
    end else if (pkt.fire) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.fire) begin
      buttons <= {pkt.status[ST_MIDDLE], pkt.status[ST_RIGHT], pkt.status[ST_LEFT]};
    end
  end

  assign res.valid          = valid;
  assign res.cursor_x       = pos_x;
  assign res.cursor_y       = pos_y;
  assign res.left_pressed   = buttons[0];
  assign res.right_pressed  = buttons[1];
  assign res.middle_pressed = buttons[2];

endmodule

`default_nettype wire

/* rtl/ps2_mouse_packet_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Turns PS/2 mouse words into a clamped cursor position and button state.
// ----------------------------------------------------------------------------
// rx carries one mouse word per handshake. The first word after reset is
// dropped; packets start on a word with bit 3 set and run status, X, Y.
// cursor carries one word per completed packet: clamped position and the
// three buttons. Other words produce nothing.
// The result word is valid the cycle after the Y word is accepted.
// Throughput: one rx word per cycle while rx.ready is high; the position
// register feeds back through one add and clamp.
// Stall: rx stays ready while a result waits, except when the pending word
// would complete a packet; then rx.ready drops until cursor is taken.
// Reset (rst, synchronous): cursor at 0,0, screen 1024 x 768, waiting for a
// status word with the first word to be dropped. cfg_we/cfg_index/cfg_data
// write screen_width (index 0) or screen_height (index 1); user: idle only, unenforced.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker import ps2mt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  ps2mt_byte_if.sink                rx,
  ps2mt_cursor_if.source            cursor
);

  pkt_t pkt;
  logic accept;

  assign rx.ready = !pkt.expect_last || !cursor.valid || cursor.ready;
  assign accept   = rx.valid && rx.ready;

  ps2mt_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .pkt     (pkt)
  );

  ps2mt_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pkt       (pkt),
    .res       (cursor)
  );

endmodule

`default_nettype wire

/* rtl/ps2mt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mt_checker
// Port-level checks for the PS/2 mouse packet tracker, bound to the top.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mt_checker import ps2mt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [DIM_W-1:0]      cfg_data,
  input wire logic                  rx_valid,
  input wire logic                  rx_ready,
  input wire logic                  cursor_valid,
  input wire logic                  cursor_ready,
  input wire logic [COORD_BITS-1:0] cursor_x,
  input wire logic [COORD_BITS-1:0] cursor_y
);

  localparam int CMP_W = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;

  logic [DIM_W-1:0] width_seen, height_seen;

  // shadow of the screen registers as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      width_seen  <= RESET_WIDTH;
      height_seen <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_seen  <= cfg_data;
        CFG_HEIGHT: height_seen <= cfg_data;
        default: ;
      endcase
    end
  end

  `PS2MT_ASSERT_NEXT(a_result_holds, cursor_valid && !cursor_ready, cursor_valid && $stable(cursor_x) && $stable(cursor_y), "stalled result changed")
  `PS2MT_ASSERT_NOW(a_result_from_word, $rose(cursor_valid), $past(rx_valid && rx_ready), "result without an accepted word")
  `PS2MT_ASSERT_NOW(a_ready_only_on_stall, !rx_ready, cursor_valid && !cursor_ready, "rx held off without a stalled result")
  `PS2MT_ASSERT_NOW(a_x_in_screen, cursor_valid, (CMP_W'(cursor_x) < CMP_W'(width_seen)) || (cursor_x == '0), "cursor_x beyond screen width")
  `PS2MT_ASSERT_NOW(a_y_in_screen, cursor_valid, (CMP_W'(cursor_y) < CMP_W'(height_seen)) || (cursor_y == '0), "cursor_y beyond screen height")

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker #(
  .COORD_BITS (COORD_BITS)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data),
  .rx_valid     (rx.valid),
  .rx_ready     (rx.ready),
  .cursor_valid (cursor.valid),
  .cursor_ready (cursor.ready),
  .cursor_x     (cursor.cursor_x),
  .cursor_y     (cursor.cursor_y)
);

`default_nettype wire
